[hw/rtl/ddoy_pkg.sv]
// shared types, status codes and month-length table for the day-of-year converter
package ddoy_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_REM,
      ST_CHECK,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BAD_YEAR  = 2'd1;
   localparam status_type STATUS_BAD_MONTH = 2'd2;
   localparam status_type STATUS_BAD_DAY   = 2'd3;

   localparam logic CMD_TO_YEAR_DAY = 1'b0;
   localparam logic CMD_TO_DATE     = 1'b1;

   localparam logic [3:0] MONTH_FIRST = 4'd1;
   localparam logic [3:0] MONTH_LAST  = 4'd12;

   localparam logic [9:0] CYCLE_400  = 10'd400;
   localparam logic [8:0] DAYS_LEAP  = 9'd366;
   localparam logic [8:0] DAYS_PLAIN = 9'd365;

   // days in a month, zero for codes that are no month
   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

[hw/rtl/date_day_of_year_converter.sv]
// gregorian date to day-of-year converter in both directions, one shared add/sub unit
// steps: year zero goes straight to the strobe; otherwise a multiply by the reciprocal of 400,
//   the remainder on the add/sub unit, the checks, then, if they pass, a month walk of one
//   month per cycle on the same 10-bit unit
// a new item is taken only once the last one is through; busy stays high until the result
//   has been shown; the result is shown for one cycle on rsp_valid, the receiver cannot stall
// reset: synchronous, active high, returns the sequencer to idle with no result pending
module date_day_of_year_converter #(
   parameter int YEAR_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_command,
   input  logic [YEAR_WIDTH-1:0]  req_year,
   input  logic [3:0]             req_month,
   input  logic [4:0]             req_day_of_month,
   input  logic [8:0]             req_year_day,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [8:0]             rsp_year_day_out,
   output logic [3:0]             rsp_month_out,
   output logic [4:0]             rsp_day_out
);

   localparam int RECIP_W = YEAR_WIDTH + 1;
   localparam int PROD_W  = 2 * YEAR_WIDTH + 1;
   // reciprocal of 400 rounded up, exact quotient for every year of YEAR_WIDTH bits
   localparam logic [RECIP_W-1:0] RECIP_400 =
      RECIP_W'(((64'd1 << (YEAR_WIDTH + 9)) / 64'(ddoy_pkg::CYCLE_400)) + 64'd1);

   ddoy_pkg::state_type state_ff, state_in;

   // item registers
   logic                  cmd_ff, cmd_in;
   logic [YEAR_WIDTH-1:0] year_ff, year_in;     // held for the reciprocal multiply
   logic [1:0]            year_lo_ff, year_lo_in;
   logic [3:0]            month_ff, month_in;
   logic [4:0]            dom_ff, dom_in;
   logic [8:0]            yd_ff, yd_in;

   // working registers
   logic [8:0]            quot_ff, quot_in;     // low bits of year / 400
   logic [8:0]            rem_ff, rem_in;       // year mod 400
   logic [8:0]            acc_ff, acc_in;       // day sum or remaining days
   logic [3:0]            idx_ff, idx_in;       // month under test
   logic                  leap_ff, leap_in;
   ddoy_pkg::status_type  status_ff, status_in;

   // shared add/sub unit
   logic [9:0]  alu_a, alu_b;
   logic        alu_sub;
   logic [10:0] alu_sum;

   assign alu_sum = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});

   // helpers
   logic [PROD_W-1:0] recip_prod;
   logic [8:0] quot_400;
   logic       leap_now;
   logic [4:0] walk_len;
   logic [4:0] check_len;
   logic [8:0] yd_limit;
   logic       walk_more;

   // constant multiply, the quotient sits at bit YEAR_WIDTH + 9 and above
   assign recip_prod = PROD_W'(year_ff) * PROD_W'(RECIP_400);

   // quotient times 400 = 256 + 128 + 16, only the low 9 bits matter for the remainder
   assign quot_400 = {quot_ff[0], 8'd0} + {quot_ff[1:0], 7'd0} + {quot_ff[4:0], 4'd0};

   // leap: divisible by 4 and not by 100, or by 400; rem_ff holds year mod 400 here
   assign leap_now = ((year_lo_ff == 2'd0) &&
                      !((rem_ff == 9'd0) || (rem_ff == 9'd100) ||
                        (rem_ff == 9'd200) || (rem_ff == 9'd300)))
                     || (rem_ff == 9'd0);

   assign walk_len  = ddoy_pkg::month_len(leap_ff, idx_ff);
   assign check_len = ddoy_pkg::month_len(leap_now, month_ff);
   assign yd_limit  = leap_now ? ddoy_pkg::DAYS_LEAP : ddoy_pkg::DAYS_PLAIN;

   // unit operands by phase
   always_comb begin
      alu_a   = 10'd0;
      alu_b   = 10'd0;
      alu_sub = 1'b0;
      if (state_ff == ddoy_pkg::ST_REM) begin
         // remainder below 400 fits in 9 bits, so the low bits of the difference are exact
         alu_a   = {1'b0, year_ff[8:0]};
         alu_b   = {1'b0, quot_400};
         alu_sub = 1'b1;
      end else if (state_ff == ddoy_pkg::ST_WALK) begin
         alu_a   = {1'b0, acc_ff};
         alu_b   = {5'd0, walk_len};
         alu_sub = (cmd_ff == ddoy_pkg::CMD_TO_DATE);
      end
   end

   // whether the month walk takes another step this cycle
   always_comb begin
      if (cmd_ff == ddoy_pkg::CMD_TO_YEAR_DAY) begin
         walk_more = (idx_ff < month_ff);
      end else begin
         // remaining days exceed this month: no borrow and a nonzero difference
         walk_more = (idx_ff < ddoy_pkg::MONTH_LAST) && !alu_sum[10] && (alu_sum[9:0] != 10'd0);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddoy_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_year == '0) ? ddoy_pkg::ST_DONE : ddoy_pkg::ST_MOD;
            end
         end
         ddoy_pkg::ST_MOD: begin
            state_in = ddoy_pkg::ST_REM;
         end
         ddoy_pkg::ST_REM: begin
            state_in = ddoy_pkg::ST_CHECK;
         end
         ddoy_pkg::ST_CHECK: begin
            if (cmd_ff == ddoy_pkg::CMD_TO_YEAR_DAY) begin
               if ((month_ff < ddoy_pkg::MONTH_FIRST) || (month_ff > ddoy_pkg::MONTH_LAST) ||
                   (dom_ff == 5'd0) || (dom_ff > check_len)) begin
                  state_in = ddoy_pkg::ST_DONE;
               end else begin
                  state_in = ddoy_pkg::ST_WALK;
               end
            end else begin
               if ((yd_ff == 9'd0) || (yd_ff > yd_limit)) state_in = ddoy_pkg::ST_DONE;
               else                                       state_in = ddoy_pkg::ST_WALK;
            end
         end
         ddoy_pkg::ST_WALK: begin
            if (!walk_more) state_in = ddoy_pkg::ST_DONE;
         end
         ddoy_pkg::ST_DONE: begin
            state_in = ddoy_pkg::ST_IDLE;
         end
         default: state_in = ddoy_pkg::ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      cmd_in     = cmd_ff;
      year_in    = year_ff;
      year_lo_in = year_lo_ff;
      month_in   = month_ff;
      dom_in     = dom_ff;
      yd_in      = yd_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      idx_in     = idx_ff;
      leap_in    = leap_ff;
      status_in  = status_ff;
      unique case (state_ff)
         ddoy_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in     = req_command;
               year_in    = req_year;
               year_lo_in = req_year[1:0];
               month_in   = req_month;
               dom_in     = req_day_of_month;
               yd_in      = req_year_day;
               rem_in     = 9'd0;
               status_in  = (req_year == '0) ? ddoy_pkg::STATUS_BAD_YEAR : ddoy_pkg::STATUS_OK;
            end
         end
         ddoy_pkg::ST_MOD: begin
            // quotient by 400 from the reciprocal product
            quot_in = 9'(recip_prod >> (YEAR_WIDTH + 9));
         end
         ddoy_pkg::ST_REM: begin
            rem_in = alu_sum[8:0];
         end
         ddoy_pkg::ST_CHECK: begin
            leap_in = leap_now;
            idx_in  = ddoy_pkg::MONTH_FIRST;
            if (cmd_ff == ddoy_pkg::CMD_TO_YEAR_DAY) begin
               acc_in = {4'd0, dom_ff};
               if ((month_ff < ddoy_pkg::MONTH_FIRST) || (month_ff > ddoy_pkg::MONTH_LAST)) begin
                  status_in = ddoy_pkg::STATUS_BAD_MONTH;
               end else if ((dom_ff == 5'd0) || (dom_ff > check_len)) begin
                  status_in = ddoy_pkg::STATUS_BAD_DAY;
               end
            end else begin
               acc_in = yd_ff;
               if ((yd_ff == 9'd0) || (yd_ff > yd_limit)) status_in = ddoy_pkg::STATUS_BAD_DAY;
            end
         end
         ddoy_pkg::ST_WALK: begin
            if (walk_more) begin
               acc_in = alu_sum[8:0];
               idx_in = idx_ff + 4'd1;
            end
         end
         ddoy_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddoy_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      year_ff    <= year_in;
      year_lo_ff <= year_lo_in;
      month_ff   <= month_in;
      dom_ff     <= dom_in;
      yd_ff      <= yd_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      acc_ff     <= acc_in;
      idx_ff     <= idx_in;
      leap_ff    <= leap_in;
      status_ff  <= status_in;
   end

   // result ports from registers, gated by status and direction; numeric fields zero on any error
   logic rsp_ok;
   assign rsp_ok           = (status_ff == ddoy_pkg::STATUS_OK);
   assign busy             = (state_ff != ddoy_pkg::ST_IDLE);
   assign rsp_valid        = (state_ff == ddoy_pkg::ST_DONE);
   assign rsp_status       = status_ff;
   assign rsp_year_day_out = (rsp_ok && (cmd_ff == ddoy_pkg::CMD_TO_YEAR_DAY)) ? acc_ff : 9'd0;
   assign rsp_month_out    = (rsp_ok && (cmd_ff == ddoy_pkg::CMD_TO_DATE)) ? idx_ff : 4'd0;
   assign rsp_day_out      = (rsp_ok && (cmd_ff == ddoy_pkg::CMD_TO_DATE)) ? acc_ff[4:0] : 5'd0;

   // an item accepted always makes the block busy on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // the strobe lasts exactly one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // errors zero every numeric field
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ddoy_pkg::STATUS_OK)) |->
      ((rsp_year_day_out == 9'd0) && (rsp_month_out == 4'd0) && (rsp_day_out == 5'd0)))
      else $error("error result carries nonzero fields");

   // a good date result has a month in range
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ddoy_pkg::STATUS_OK) && (rsp_month_out != 4'd0)) |->
      ((rsp_month_out <= ddoy_pkg::MONTH_LAST) && (rsp_day_out != 5'd0)))
      else $error("month walk ended out of range");

endmodule

[test/date_day_of_year_converter_tb.sv]
// self-checking testbench for the gregorian date / day-of-year converter
`timescale 1ns / 1ps

module date_day_of_year_converter_tb;

   localparam int YEAR_W = 16;
   // worst item: its time in the block plus a long sender gap, several times over
   localparam int CYCLE_LIMIT = 400000;
   // cycles to wait after the last result, above the block's longest latency
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 190;

   // short names for the two directions in the table
   localparam logic CMD_DAY  = ddoy_pkg::CMD_TO_YEAR_DAY;
   localparam logic CMD_DATE = ddoy_pkg::CMD_TO_DATE;

   // one request as it goes onto the req_ ports
   typedef struct packed {
      logic              cmd;
      logic [YEAR_W-1:0] year;
      logic [3:0]        month;
      logic [4:0]        dom;
      logic [8:0]        yd;
   } date_req_type;

   // one result as it comes off the rsp_ ports
   typedef struct packed {
      ddoy_pkg::status_type status;
      logic [8:0]           year_day;
      logic [3:0]           month;
      logic [4:0]           day;
   } date_result_type;

   // directed row: a request and, where it is obvious, the result typed in by hand
   typedef struct packed {
      date_req_type    req;
      logic            typed;
      date_result_type res;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_command;
   logic [YEAR_W-1:0] req_year;
   logic [3:0]        req_month;
   logic [4:0]        req_day_of_month;
   logic [8:0]        req_year_day;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [8:0]        rsp_year_day_out;
   logic [3:0]        rsp_month_out;
   logic [4:0]        rsp_day_out;

   // typed-in result travels with the request so the monitor picks it up race free
   logic              typed_valid;
   date_result_type   typed_res;

   date_result_type   expected_dates[$];
   stim_row_type      directed_rows[$];
   int                mismatches = 0;
   int                results_seen = 0;
   int                cycles = 0;

   date_day_of_year_converter #(
      .YEAR_WIDTH(YEAR_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_year(req_year),
      .req_month(req_month),
      .req_day_of_month(req_day_of_month),
      .req_year_day(req_year_day),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_year_day_out(rsp_year_day_out),
      .rsp_month_out(rsp_month_out),
      .rsp_day_out(rsp_day_out)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // gregorian rule: every fourth year, but not centuries unless divisible by 400
   function automatic logic leap_year(input logic [YEAR_W-1:0] year);
      int y;
      y = int'(year);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // month length, called only with months 1..12
   function automatic int month_days(input logic leap, input int month);
      case (month)
         2:             return leap ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   // expected result of one request; checks go year, month, day in that order
   function automatic date_result_type convert_date(input date_req_type r);
      date_result_type res;
      logic            leap;
      int              acc;
      int              m;
      int              days_in_year;
      res = '0;
      res.status = ddoy_pkg::STATUS_OK;
      leap = leap_year(r.year);
      if (r.year == '0) begin
         res.status = ddoy_pkg::STATUS_BAD_YEAR;
      end else if (r.cmd == ddoy_pkg::CMD_TO_YEAR_DAY) begin
         if (r.month < ddoy_pkg::MONTH_FIRST || r.month > ddoy_pkg::MONTH_LAST) begin
            res.status = ddoy_pkg::STATUS_BAD_MONTH;
         end else if (r.dom == 0 || int'(r.dom) > month_days(leap, int'(r.month))) begin
            res.status = ddoy_pkg::STATUS_BAD_DAY;
         end else begin
            // sum the full months before, then add the day
            acc = int'(r.dom);
            for (m = 1; m < int'(r.month); m++) acc += month_days(leap, m);
            res.year_day = acc[8:0];
         end
      end else begin
         days_in_year = leap ? 366 : 365;
         if (r.yd == 0 || int'(r.yd) > days_in_year) begin
            res.status = ddoy_pkg::STATUS_BAD_DAY;
         end else begin
            // peel whole months off until the rest fits in one
            acc = int'(r.yd);
            m = 1;
            while (m < 12 && acc > month_days(leap, m)) begin
               acc -= month_days(leap, m);
               m++;
            end
            res.month = m[3:0];
            res.day = acc[4:0];
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch on result %0d: %s is %0d, expected %0d", results_seen, field, got,
               want);
      mismatches++;
   endtask

   // results are compared first, then a newly taken item queues its expectation
   always @(posedge clock) begin
      date_result_type want;
      date_req_type    taken;
      if (!reset) begin
         if (rsp_valid) begin
            results_seen++;
            if (expected_dates.size() == 0) begin
               report_mismatch("items outstanding", 0, 1);
            end else begin
               want = expected_dates.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
               if (rsp_year_day_out != want.year_day)
                  report_mismatch("year_day_out", int'(rsp_year_day_out),
                                  int'(want.year_day));
               if (rsp_month_out != want.month)
                  report_mismatch("month_out", int'(rsp_month_out), int'(want.month));
               if (rsp_day_out != want.day)
                  report_mismatch("day_out", int'(rsp_day_out), int'(want.day));
            end
         end
         if (start && !busy) begin
            taken = '{req_command, req_year, req_month, req_day_of_month, req_year_day};
            expected_dates.push_back(typed_valid ? typed_res : convert_date(taken));
         end
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_dates.size());
         $display("date_day_of_year_converter_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_row(input logic cmd, input int year, input int month, input int dom,
                          input int yd, input logic typed, input ddoy_pkg::status_type st,
                          input int yd_o, input int m_o, input int d_o);
      stim_row_type row;
      row.req = '{cmd, year[YEAR_W-1:0], month[3:0], dom[4:0], yd[8:0]};
      row.typed = typed;
      row.res = '{st, yd_o[8:0], m_o[3:0], d_o[4:0]};
      directed_rows.push_back(row);
   endtask

   // called on a rising edge; idles at random, then holds the item until it is taken
   task automatic drive_item(input stim_row_type row, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_command      <= row.req.cmd;
      req_year         <= row.req.year;
      req_month        <= row.req.month;
      req_day_of_month <= row.req.dom;
      req_year_day     <= row.req.yd;
      typed_valid      <= row.typed;
      typed_res        <= row.res;
      do @(posedge clock); while (!(start && !busy));
   endtask

   // sender holds off until every outstanding result is back
   task automatic wait_all_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_dates.size() != 0) @(posedge clock);
   endtask

   // random request, mostly well formed so the month walk gets exercised
   function automatic stim_row_type random_row();
      stim_row_type row;
      int           sel;
      int           y;
      logic         leap;
      row = '0;
      sel = $urandom_range(99);
      if (sel < 3)       y = 0;
      else if (sel < 35) y = $urandom_range(65535, 1);
      else if (sel < 50) y = $urandom_range(163, 1) * 400;
      else if (sel < 65) y = $urandom_range(655, 1) * 100;
      else if (sel < 80) y = $urandom_range(16383, 1) * 4;
      else               y = $urandom_range(2100, 1);
      row.req.year = y[YEAR_W-1:0];
      row.req.cmd = 1'($urandom_range(1));
      leap = leap_year(row.req.year);
      // unused fields get full-range noise
      row.req.month = 4'($urandom_range(15));
      row.req.dom = 5'($urandom_range(31));
      row.req.yd = 9'($urandom_range(511));
      if (row.req.cmd == ddoy_pkg::CMD_TO_YEAR_DAY) begin
         if ($urandom_range(99) < 85) row.req.month = 4'($urandom_range(12, 1));
         if (row.req.month >= ddoy_pkg::MONTH_FIRST && row.req.month <= ddoy_pkg::MONTH_LAST &&
             $urandom_range(99) < 85)
            row.req.dom = 5'($urandom_range(month_days(leap, int'(row.req.month)), 1));
      end else if ($urandom_range(99) < 85) begin
         row.req.yd = 9'($urandom_range(leap ? 366 : 365, 1));
      end
      return row;
   endfunction

   initial begin
      int idle_pct[4];
      int ph;
      int i;

      idle_pct         = '{0, 64, 0, 29};
      reset            <= 1'b1;
      start            <= 1'b0;
      req_command      <= 1'b0;
      req_year         <= '0;
      req_month        <= '0;
      req_day_of_month <= '0;
      req_year_day     <= '0;
      typed_valid      <= 1'b0;
      typed_res        <= '0;

      // directed table: cmd, year, month, day, year day, typed?, expected fields
      // year zero wins over every other check
      add_row(CMD_DAY, 0, 1, 1, 0, 1'b1, ddoy_pkg::STATUS_BAD_YEAR, 0, 0, 0);
      add_row(CMD_DATE, 0, 0, 0, 1, 1'b1, ddoy_pkg::STATUS_BAD_YEAR, 0, 0, 0);
      add_row(CMD_DAY, 0, 0, 0, 0, 1'b1, ddoy_pkg::STATUS_BAD_YEAR, 0, 0, 0);
      // months that do not exist, month checked before day
      add_row(CMD_DAY, 2023, 0, 1, 0, 1'b1, ddoy_pkg::STATUS_BAD_MONTH, 0, 0, 0);
      add_row(CMD_DAY, 2023, 13, 0, 0, 1'b1, ddoy_pkg::STATUS_BAD_MONTH, 0, 0, 0);
      add_row(CMD_DAY, 2023, 15, 31, 0, 1'b1, ddoy_pkg::STATUS_BAD_MONTH, 0, 0, 0);
      // days outside the month, feb 29 across the leap rule
      add_row(CMD_DAY, 2023, 1, 0, 0, 1'b1, ddoy_pkg::STATUS_BAD_DAY, 0, 0, 0);
      add_row(CMD_DAY, 2023, 2, 29, 0, 1'b1, ddoy_pkg::STATUS_BAD_DAY, 0, 0, 0);
      add_row(CMD_DAY, 1900, 2, 29, 0, 1'b1, ddoy_pkg::STATUS_BAD_DAY, 0, 0, 0);
      add_row(CMD_DAY, 2023, 4, 31, 0, 1'b1, ddoy_pkg::STATUS_BAD_DAY, 0, 0, 0);
      add_row(CMD_DAY, 2024, 2, 29, 0, 1'b0, ddoy_pkg::STATUS_OK, 0, 0, 0);
      add_row(CMD_DAY, 2000, 2, 29, 0, 1'b0, ddoy_pkg::STATUS_OK, 0, 0, 0);
      // first and last day of the year; year day input is ignored here
      add_row(CMD_DAY, 1, 1, 1, 0, 1'b1, ddoy_pkg::STATUS_OK, 1, 0, 0);
      add_row(CMD_DAY, 2024, 12, 31, 511, 1'b1, ddoy_pkg::STATUS_OK, 366, 0, 0);
      add_row(CMD_DAY, 65535, 12, 31, 0, 1'b1, ddoy_pkg::STATUS_OK, 365, 0, 0);
      // day of year range
      add_row(CMD_DATE, 2023, 0, 0, 0, 1'b1, ddoy_pkg::STATUS_BAD_DAY, 0, 0, 0);
      add_row(CMD_DATE, 2023, 0, 0, 366, 1'b1, ddoy_pkg::STATUS_BAD_DAY, 0, 0, 0);
      add_row(CMD_DATE, 2024, 0, 0, 367, 1'b1, ddoy_pkg::STATUS_BAD_DAY, 0, 0, 0);
      add_row(CMD_DATE, 2023, 0, 0, 511, 1'b1, ddoy_pkg::STATUS_BAD_DAY, 0, 0, 0);
      add_row(CMD_DATE, 1, 0, 0, 1, 1'b1, ddoy_pkg::STATUS_OK, 0, 1, 1);
      add_row(CMD_DATE, 2024, 0, 0, 366, 1'b1, ddoy_pkg::STATUS_OK, 0, 12, 31);
      // month and day inputs are ignored for this direction, even when bad
      add_row(CMD_DATE, 65535, 15, 31, 365, 1'b1, ddoy_pkg::STATUS_OK, 0, 12, 31);
      // around feb 29 in a skipped century and a 400th year
      add_row(CMD_DATE, 2100, 0, 0, 60, 1'b0, ddoy_pkg::STATUS_OK, 0, 0, 0);
      add_row(CMD_DATE, 2000, 0, 0, 60, 1'b0, ddoy_pkg::STATUS_OK, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) drive_item(directed_rows[i], 0);
      wait_all_results();

      // random phases: back to back, sparse sender, back to back, light gaps
      for (ph = 0; ph < 4; ph++) begin
         for (i = 0; i < ITEMS_PER_PHASE; i++) drive_item(random_row(), idle_pct[ph]);
         wait_all_results();
      end

      // let any stray result show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("date_day_of_year_converter_tb passed");
      else
         $display("date_day_of_year_converter_tb failed");
      $finish;
   end

endmodule
